// ----- rtl/ntcat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcat_pkg
// Shared types, constants and thermistor curve tables for the NTC converter.
// ----------------------------------------------------------------------------
package ntcat_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int INDEX_W       = 8;
    localparam int CURVE_W       = 12;
    localparam int CURVE_LEN     = 110;
    localparam int TEMP_W        = 11;
    localparam int DEF_TABLE_ENTRIES = 110;
    localparam int DEF_ADC_BITS  = 12;

    localparam logic [SAMPLE_W-1:0] ADC_FAULT_HIGH = 16'd4050;
    localparam logic [SAMPLE_W-1:0] ADC_FAULT_LOW  = 16'd30;
    localparam logic [TEMP_W-1:0]   TEMP_FAULT     = 11'sd999;
    localparam logic [TEMP_W-1:0]   TEMP_COLD_END  = -11'sd95;
    localparam logic [TEMP_W-1:0]   TEMP_HOT_END   = 11'sd995;

    // payload carried down the pipeline
    typedef struct packed {
        logic                  ch;
        logic                  tsel;
        logic                  fault;
        logic                  cold;
        logic                  hot;
        logic [SAMPLE_W-1:0]   sample;
        logic [INDEX_W-1:0]    pos;
        logic [CURVE_W-1:0]    step;
        logic [SAMPLE_W-1:0]   rem;
        logic [3:0]            quot;
    } item_t;

    localparam logic [CURVE_W-1:0] CURVE_3380 [CURVE_LEN] = '{
        12'd3314,12'd3285,12'd3255,12'd3225,12'd3194,12'd3162,12'd3130,12'd3098,12'd3064,12'd3031,
        12'd2996,12'd2962,12'd2927,12'd2891,12'd2855,12'd2818,12'd2781,12'd2744,12'd2706,12'd2669,
        12'd2630,12'd2592,12'd2553,12'd2515,12'd2476,12'd2437,12'd2398,12'd2359,12'd2319,12'd2280,
        12'd2241,12'd2202,12'd2163,12'd2125,12'd2086,12'd2048,12'd2009,12'd1971,12'd1933,12'd1896,
        12'd1859,12'd1822,12'd1785,12'd1749,12'd1714,12'd1678,12'd1643,12'd1607,12'd1575,12'd1541,
        12'd1508,12'd1475,12'd1443,12'd1411,12'd1379,12'd1349,12'd1319,12'd1289,12'd1259,12'd1231,
        12'd1203,12'd1175,12'd1148,12'd1122,12'd1096,12'd1070,12'd1045,12'd1021,12'd997, 12'd973,
        12'd950, 12'd927, 12'd905, 12'd883, 12'd862, 12'd842, 12'd822, 12'd802, 12'd783, 12'd764,
        12'd746, 12'd728, 12'd710, 12'd693, 12'd677, 12'd661, 12'd645, 12'd629, 12'd614, 12'd599,
        12'd585, 12'd571, 12'd558, 12'd544, 12'd531, 12'd518, 12'd506, 12'd495, 12'd483, 12'd471,
        12'd460, 12'd449, 12'd439, 12'd428, 12'd418, 12'd409, 12'd399, 12'd389, 12'd381, 12'd372
    };

    localparam logic [CURVE_W-1:0] CURVE_3950 [CURVE_LEN] = '{
        12'd3049,12'd3004,12'd2958,12'd2912,12'd2865,12'd2817,12'd2768,12'd2719,12'd2669,12'd2619,
        12'd2568,12'd2517,12'd2466,12'd2415,12'd2364,12'd2312,12'd2261,12'd2210,12'd2158,12'd2108,
        12'd2057,12'd2007,12'd1957,12'd1907,12'd1858,12'd1810,12'd1762,12'd1715,12'd1669,12'd1623,
        12'd1578,12'd1534,12'd1491,12'd1448,12'd1406,12'd1365,12'd1325,12'd1286,12'd1248,12'd1211,
        12'd1174,12'd1139,12'd1104,12'd1070,12'd1037,12'd1005,12'd974, 12'd944, 12'd915, 12'd886,
        12'd858, 12'd831, 12'd805, 12'd780, 12'd755, 12'd731, 12'd708, 12'd686, 12'd664, 12'd643,
        12'd623, 12'd603, 12'd584, 12'd566, 12'd548, 12'd531, 12'd514, 12'd498, 12'd483, 12'd467,
        12'd453, 12'd439, 12'd425, 12'd412, 12'd399, 12'd387, 12'd375, 12'd364, 12'd352, 12'd342,
        12'd331, 12'd321, 12'd312, 12'd302, 12'd293, 12'd284, 12'd276, 12'd268, 12'd260, 12'd252,
        12'd245, 12'd237, 12'd231, 12'd224, 12'd217, 12'd211, 12'd205, 12'd199, 12'd193, 12'd188,
        12'd183, 12'd178, 12'd173, 12'd168, 12'd163, 12'd159, 12'd154, 12'd150, 12'd146, 12'd142
    };

    // curve read, entries past the stored curve read as zero
    function automatic logic [CURVE_W-1:0] curve_rd(input logic sel,
                                                   input logic [INDEX_W-1:0] idx);
        logic [CURVE_W-1:0] val;
        val = '0;
        if (idx < INDEX_W'(CURVE_LEN)) begin
            val = sel ? CURVE_3950[idx[6:0]] : CURVE_3380[idx[6:0]];
        end
        return val;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ntcat_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcat_search
// One binary search step: settles one bit of the index of the first curve
// entry at or below the sample.
// ----------------------------------------------------------------------------
module ntcat_search #(
    parameter int BIT  = 7,
    parameter int LAST = 109
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  ntcat_pkg::item_t     in_item,
    output logic                 out_valid,
    output ntcat_pkg::item_t     out_item
);
    import ntcat_pkg::*;

    logic [INDEX_W-1:0] probe;
    logic               found;
    item_t              item_next;
    item_t              item_reg;
    logic               valid_reg;

    // probe the last index of the lower half still open
    always_comb begin
        probe = in_item.pos | INDEX_W'((1 << BIT) - 1);
        found = (probe >= INDEX_W'(LAST)) ||
                ({4'd0, curve_rd(in_item.tsel, probe)} <= in_item.sample);
        item_next = in_item;
        if (!found) begin
            item_next.pos = in_item.pos | INDEX_W'(1 << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- rtl/ntcat_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcat_div
// One restoring division step: yields one quotient bit of the tenths fraction.
// ----------------------------------------------------------------------------
module ntcat_div #(
    parameter int BIT = 3
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  ntcat_pkg::item_t     in_item,
    output logic                 out_valid,
    output ntcat_pkg::item_t     out_item
);
    import ntcat_pkg::*;

    logic [SAMPLE_W:0] shifted;
    item_t             item_next;
    item_t             item_reg;
    logic              valid_reg;

    // trial subtract of the shifted step
    always_comb begin
        shifted   = (SAMPLE_W+1)'(in_item.step) << BIT;
        item_next = in_item;
        if ({1'b0, in_item.rem} >= shifted) begin
            item_next.rem       = in_item.rem - shifted[SAMPLE_W-1:0];
            item_next.quot[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- rtl/ntc_adc_to_temperature.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// NTC thermistor ADC sample to temperature in tenths of a degree C.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word: tdata holds the ADC reading, tuser the
//   channel (0 inside, 1 outside). m_axis returns one word per sample:
//   tdata holds the signed temperature in 0.1 C, tuser the channel and the
//   sensor fault flag.
//   cfg_valid/cfg_data writes the outside curve select (0 B3380/10k,
//   1 B3950/5k); cfg_ready is always high.
//   The pipeline is an input stage, eight binary search steps over the curve,
//   a step setup stage, four division steps and the output stage. One word
//   is taken each cycle while the output is not stalled.
//   When m_tready is low with a word waiting, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets the curve select to B3380/10k.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature #(
    parameter int TABLE_ENTRIES = ntcat_pkg::DEF_TABLE_ENTRIES,
    parameter int ADC_BITS      = ntcat_pkg::DEF_ADC_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [0:0]                       cfg_data,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // adc_sample
    input  wire  [((ADC_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // channel
    input  wire  [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // temperature_tenths
    output logic [15:0]                      m_axis_tdata,
    // channel_echo, sensor_fault
    output logic [1:0]                       m_axis_tuser
);
    import ntcat_pkg::*;

    localparam int ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                             ((TABLE_ENTRIES > 256) ? 256 : TABLE_ENTRIES);
    localparam int LAST    = ENTRIES - 1;
    localparam int NSRCH   = INDEX_W;
    localparam int NDIV    = 4;

    logic        sel_reg;
    logic        en;
    logic [SAMPLE_W-1:0] sample;
    item_t       in_next;
    item_t       in_reg;
    logic        in_valid_reg;

    logic        srch_valid [NSRCH+1];
    item_t       srch_item  [NSRCH+1];
    logic        div_valid  [NDIV+1];
    item_t       div_item   [NDIV+1];

    item_t       prep_next;
    item_t       prep_reg;
    logic        prep_valid_reg;

    logic [CURVE_W-1:0]  hi;
    logic [CURVE_W-1:0]  lo;
    logic [SAMPLE_W-1:0] diff;
    logic [4:0]          frac;
    logic [12:0]         interp;
    logic [TEMP_W-1:0]   temp_next;
    logic [TEMP_W-1:0]   temp_reg;
    logic                ch_reg;
    logic                fault_reg;
    logic                out_valid_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else if (cfg_valid) begin
            sel_reg <= cfg_data[0];
        end
    end

    // pipeline advances whenever the output slot is free or being taken
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // input stage: range and table end checks
    always_comb begin
        sample         = SAMPLE_W'(s_axis_tdata[ADC_BITS-1:0]);
        in_next        = '0;
        in_next.ch     = s_axis_tuser[0];
        in_next.tsel   = s_axis_tuser[0] & sel_reg;
        in_next.sample = sample;
        in_next.fault  = (sample > ADC_FAULT_HIGH) || (sample < ADC_FAULT_LOW);
        in_next.cold   = sample > {4'd0, curve_rd(in_next.tsel, '0)};
        in_next.hot    = sample < {4'd0, curve_rd(in_next.tsel, INDEX_W'(LAST))};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_next;
        end
    end

    assign srch_valid[0] = in_valid_reg;
    assign srch_item[0]  = in_reg;

    // binary search, most significant index bit first
    for (genvar k = 0; k < NSRCH; k++) begin : g_srch
        ntcat_search #(
            .BIT  (NSRCH - 1 - k),
            .LAST (LAST)
        ) u_search (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (srch_valid[k]),
            .in_item   (srch_item[k]),
            .out_valid (srch_valid[k+1]),
            .out_item  (srch_item[k+1])
        );
    end

    // step setup: neighbouring entries, numerator in tenths
    always_comb begin
        hi        = curve_rd(srch_item[NSRCH].tsel, srch_item[NSRCH].pos - INDEX_W'(1));
        lo        = curve_rd(srch_item[NSRCH].tsel, srch_item[NSRCH].pos);
        diff      = srch_item[NSRCH].sample - {4'd0, lo};
        prep_next = srch_item[NSRCH];
        prep_next.quot = '0;
        if ((srch_item[NSRCH].pos != '0) && (hi > lo)) begin
            prep_next.step = hi - lo;
            prep_next.rem  = (diff << 3) + (diff << 1);
        end else begin
            // flat step or first entry: fraction is zero
            prep_next.step = CURVE_W'(1);
            prep_next.rem  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= srch_valid[NSRCH];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign div_valid[0] = prep_valid_reg;
    assign div_item[0]  = prep_reg;

    // quotient bits, most significant first
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        ntcat_div #(
            .BIT (NDIV - 1 - k)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_item   (div_item[k]),
            .out_valid (div_valid[k+1]),
            .out_item  (div_item[k+1])
        );
    end

    // rounding and final selection
    always_comb begin
        frac = {1'b0, div_item[NDIV].quot} +
               5'(div_item[NDIV].rem > {5'd0, div_item[NDIV].step[CURVE_W-1:1]});
        interp = 13'(div_item[NDIV].pos) * 13'd10 - 13'd100 - 13'(frac);
        if (div_item[NDIV].fault) begin
            temp_next = TEMP_FAULT;
        end else if (div_item[NDIV].cold) begin
            temp_next = TEMP_COLD_END;
        end else if (div_item[NDIV].hot) begin
            temp_next = TEMP_HOT_END;
        end else begin
            temp_next = interp[TEMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_valid[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg  <= temp_next;
            ch_reg    <= div_item[NDIV].ch;
            fault_reg <= div_item[NDIV].fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-TEMP_W){temp_reg[TEMP_W-1]}}, temp_reg};
    assign m_axis_tuser  = {fault_reg, ch_reg};

    // checks
    a_fault_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[TEMP_W-1:0] == TEMP_FAULT)
        else $error("fault word without fault temperature");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[TEMP_W-1:0]) >= -11'sd100) &&
                          ($signed(m_axis_tdata[TEMP_W-1:0]) <= 11'sd999))
        else $error("temperature out of range");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ----- bench/tb_ntc_adc_to_temperature.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntc_adc_to_temperature
// Self-checking bench for the NTC sample to temperature converter: a local
// curve lookup predicts each output word, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_ntc_adc_to_temperature;
    import ntcat_pkg::*;

    localparam int LATENCY   = 15;
    localparam int IDLE_LIMIT = 5000;
    localparam int LAST_IDX  = 109;

    typedef struct packed {
        logic              ch;
        logic [TEMP_W-1:0] temp;
        logic              fault;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_data = '0;
    logic        cfg_ready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    reading_t    pending_readings[$];
    logic        curve_sel = 1'b0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          no_stall = 1'b0;

    ntc_adc_to_temperature dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        // adc_sample
        .s_axis_tdata(s_axis_tdata),
        // channel
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        // temperature_tenths
        .m_axis_tdata(m_axis_tdata),
        // channel_echo, sensor_fault
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // curve entry, read from the package tables
    function automatic int curve_entry(input bit sel, input int idx);
        return sel ? int'(CURVE_3950[idx]) : int'(CURVE_3380[idx]);
    endfunction

    // temperature for one sample
    function automatic reading_t predict_reading(input bit ch, input int s);
        reading_t r;
        bit  sel;
        int  i, hi, lo, stp, num, frac, t;
        r.ch = ch;
        r.fault = 1'b0;
        sel = ch && curve_sel;
        frac = 0;
        i = 0;
        if (s > 4050 || s < 30) begin
            r.fault = 1'b1;
            t = 999;
        end else if (s > curve_entry(sel, 0)) begin
            t = -95;
        end else if (s < curve_entry(sel, LAST_IDX)) begin
            t = 995;
        end else begin
            while (i < LAST_IDX && s < curve_entry(sel, i)) i++;
            if (i != 0) begin
                hi = curve_entry(sel, i - 1);
                lo = curve_entry(sel, i);
                if (hi > lo) begin
                    stp = hi - lo;
                    num = (s - lo) * 10;
                    frac = num / stp;
                    if (num % stp > stp / 2) frac++;
                end
            end
            t = (i - 10) * 10 - frac;
        end
        r.temp = TEMP_W'(t);
        return r;
    endfunction

    // send one sample word, bursts broken by random gaps
    task automatic send_sample(input bit ch, input int s);
        int gap;
        if (!no_stall && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 16'(s);
        s_axis_tuser  <= ch;
        pending_readings.push_back(predict_reading(ch, s));
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_curve_sel(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        curve_sel = v;
    endtask

    // sample spread over the range, mostly inside the curves
    function automatic int random_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 4095);
            1: return $urandom_range(0, 40);
            2: return $urandom_range(4040, 4095);
            default: return $urandom_range(100, 3400);
        endcase
    endfunction

    task automatic test_range_edges();
        int edges[] = '{0, 29, 30, 31, 4049, 4050, 4051, 4095, 3314, 3315, 3049,
                        3050, 372, 371, 142, 141, 3313, 2048, 1365, 2730};
        foreach (edges[k]) send_sample(k[0], edges[k]);
        wait_drained();
    endtask

    task automatic test_curve_choice();
        write_curve_sel(1'b1);
        foreach (CURVE_3950[k]) if (k % 27 == 0) send_sample(1'b1, CURVE_3950[k]);
        send_sample(1'b1, 3049);
        send_sample(1'b0, 3314);
        send_sample(1'b1, 143);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_sample($urandom_range(0, 1), random_sample());
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1'b1;
        no_stall = 1'b1;
        repeat (40) send_sample($urandom_range(0, 1), random_sample());
        no_stall = 1'b0;
        wait_drained();
    endtask

    // receiver stall pattern and long hold-off
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 200; hold++) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 15) < 11) || ($urandom_range(0, 7) == 0);
        end
    end

    // output word check
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected output word %h/%b", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_axis_tuser[0] !== want.ch) begin
                    $error("channel_echo exp %0d got %0d", want.ch, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[TEMP_W-1:0] !== want.temp) begin
                    $error("temperature_tenths exp %0d got %0d", $signed(want.temp),
                           $signed(m_axis_tdata[TEMP_W-1:0]));
                    fail_count++;
                end
                if (m_axis_tuser[1] !== want.fault) begin
                    $error("sensor_fault exp %0d got %0d", want.fault, m_axis_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL ntc_adc_to_temperature");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_range_edges();
        test_curve_choice();
        test_random(150);
        write_curve_sel(1'b0);
        test_random(150);
        test_backpressure();
        write_curve_sel(1'b1);
        test_random(150);
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("PASS ntc_adc_to_temperature");
        else
            $display("FAIL ntc_adc_to_temperature");
        $finish;
    end
endmodule

// ----- ntc_adc_to_temperature.f -----
rtl/ntcat_pkg.sv
rtl/ntcat_search.sv
rtl/ntcat_div.sv
rtl/ntc_adc_to_temperature.sv
bench/tb_ntc_adc_to_temperature.sv
